// ===== rtl/core/lkc_pkg.sv =====
// Shared constants, types and codes for the keyed LRU cache budget manager.
// No dependencies; imported by every module of the block but lkc_ram.
package lkc_pkg;

    localparam int SLOTS         = 64;
    localparam int IDX_BITS      = $clog2(SLOTS);
    localparam int CNT_BITS      = $clog2(SLOTS + 1);
    localparam int KEY_BITS      = 64;
    localparam int SIZE_BITS     = 32;
    localparam int BYTE_BITS     = 40;
    localparam int REF_BITS      = 16;
    localparam int PASS_LIMIT    = SLOTS + 2;
    localparam int PASS_BITS     = $clog2(PASS_LIMIT + 1);

    localparam int KIND_BITS     = 3;
    localparam int STATUS_BITS   = 3;
    localparam int OCNT_BITS     = 7;
    localparam int MAXE_BITS     = 7;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 40;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_BYTES   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_ENTRIES = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_EVICT_FULL  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_EVICT_DUP   = 3'd3;

    typedef enum logic [KIND_BITS-1:0] {
        K_QUERY, K_STORE, K_RESERVE, K_EVICT,
        K_MARK_BAD, K_ACQUIRE, K_RELEASE, K_CHECK_READY
    } kind_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK, ST_NOT_FOUND, ST_NOT_READY, ST_EXISTS,
        ST_FULL, ST_BAD_VALUE, ST_REFUSED, ST_TABLE_FULL
    } status_t;

    typedef enum logic [1:0] {
        SM_KEY, SM_OLDEST, SM_FREE, SM_DEC
    } scan_mode_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]  key;
        logic                 filled;
        logic [SIZE_BITS-1:0] dsize;
        logic [SIZE_BITS-1:0] ssize;
        logic [REF_BITS-1:0]  refs;
        logic                 bad;
        logic [IDX_BITS-1:0]  rec;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

    typedef struct packed {
        logic [BYTE_BITS-1:0] max_bytes;
        logic [MAXE_BITS-1:0] max_entries;
        logic                 evict_on_full;
        logic                 evict_dup;
    } cfg_t;

    typedef struct packed {
        logic   hit;
        logic   wr;
        entry_t ent;
    } scan_res_t;

endpackage

// ===== rtl/core/lkc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lkc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/core/lkc_scan.sv =====
// Shared per-slot compare and rank-update unit used by every table sweep.
// Depends on lkc_pkg.
module lkc_scan (
    input  lkc_pkg::scan_mode_t           mode,
    input  logic                          valid,
    input  lkc_pkg::entry_t               ent,
    input  logic [lkc_pkg::KEY_BITS-1:0]  key,
    input  logic [lkc_pkg::IDX_BITS-1:0]  r,
    output lkc_pkg::scan_res_t            res
);
    import lkc_pkg::*;

    always_comb
    begin
        res.hit     = 1'b0;
        res.wr      = 1'b0;
        res.ent     = ent;
        res.ent.rec = ent.rec - 1'b1;
        case (mode)
            SM_KEY:    res.hit = valid && (ent.key == key);
            SM_OLDEST: res.hit = valid && (ent.rec == '0);
            SM_FREE:   res.hit = !valid;
            SM_DEC:    res.wr  = valid && (ent.rec > r);
            default:   res.hit = 1'b0;
        endcase
    end

endmodule

// ===== rtl/core/lkc_ctrl.sv =====
// Request sequencer: drives table sweeps through the shared scan unit,
// budget checks, evictions and the result register. Depends on lkc_pkg, lkc_scan.
module lkc_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lkc_pkg::cfg_t                     cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [lkc_pkg::KIND_BITS-1:0]     kind,
    input  logic [63:0]                       key,
    input  logic [31:0]                       data_size,
    input  logic [31:0]                       store_size,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [lkc_pkg::STATUS_BITS-1:0]   status,
    output logic [31:0]                       hit_data_size,
    output logic [31:0]                       hit_store_size,
    output logic [lkc_pkg::OCNT_BITS-1:0]     evicted_count,
    output logic [lkc_pkg::OCNT_BITS-1:0]     used_entries,
    output logic [lkc_pkg::BYTE_BITS-1:0]     used_bytes,
    output logic                              ram_we,
    output logic [lkc_pkg::IDX_BITS-1:0]      ram_wr_addr,
    output lkc_pkg::entry_t                   ram_wr_data,
    output logic [lkc_pkg::IDX_BITS-1:0]      ram_rd_addr,
    input  lkc_pkg::entry_t                   ram_rd_data
);
    import lkc_pkg::*;

    localparam int NW = (CNT_BITS > MAXE_BITS) ? CNT_BITS : MAXE_BITS;

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN, S_DISPATCH, S_TOUCH, S_WR, S_REL, S_REM, S_STORE,
        S_ROOM_N, S_OLD, S_ROOM_B, S_ROOM_B2, S_ROOM_LOOP, S_ROOM_OK,
        S_RES_ADD, S_ADD, S_DONE
    } state_t;

    state_t                 state_reg, ret_reg, ev_ret_reg;
    kind_t                  kind_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic [SIZE_BITS-1:0]   dsz_reg, ssz_reg, hd_reg, hs_reg;
    status_t                st_reg;
    logic [CNT_BITS-1:0]    ev_reg, before_reg, total_reg, cnt_reg;
    logic [IDX_BITS-1:0]    s_reg, r_reg;
    entry_t                 ent_reg;
    logic                   found_reg, fill_reg;
    scan_mode_t             mode_reg;
    logic [SLOTS-1:0]       valid_reg;
    logic [BYTE_BITS-1:0]   bytes_reg, freed_reg, need_reg, avail_reg;
    logic [PASS_BITS-1:0]   pass_reg;

    logic                   out_valid_reg;
    status_t                status_reg;
    logic [SIZE_BITS-1:0]   ohd_reg, ohs_reg;
    logic [OCNT_BITS-1:0]   oev_reg, oent_reg;
    logic [BYTE_BITS-1:0]   obytes_reg;

    logic [IDX_BITS-1:0]    p_idx;
    logic                   elem_live;
    scan_res_t              sr;

    assign p_idx     = IDX_BITS'(cnt_reg - 1'b1);
    assign elem_live = (state_reg == S_SCAN) && (cnt_reg != '0);

    lkc_scan u_scan (
        .mode  (mode_reg),
        .valid (valid_reg[p_idx]),
        .ent   (ram_rd_data),
        .key   (key_reg),
        .r     (r_reg),
        .res   (sr)
    );

    assign ram_rd_addr = cnt_reg[IDX_BITS-1:0];
    assign ram_we      = (elem_live && sr.wr) || (state_reg == S_WR);
    assign ram_wr_addr = (state_reg == S_WR) ? s_reg : p_idx;
    assign ram_wr_data = (state_reg == S_WR) ? ent_reg : sr.ent;

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign hit_data_size  = ohd_reg;
    assign hit_store_size = ohs_reg;
    assign evicted_count  = oev_reg;
    assign used_entries   = oent_reg;
    assign used_bytes     = obytes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            ev_ret_reg    <= S_IDLE;
            valid_reg     <= '0;
            total_reg     <= '0;
            bytes_reg     <= '0;
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
            fill_reg      <= 1'b0;
            mode_reg      <= SM_KEY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        kind_reg <= kind_t'(kind);
                        key_reg  <= key[KEY_BITS-1:0];
                        dsz_reg  <= data_size[SIZE_BITS-1:0];
                        ssz_reg  <= store_size[SIZE_BITS-1:0];
                        st_reg   <= (kind_t'(kind) == K_STORE
                                     && data_size[SIZE_BITS-1:0] == '0)
                                    ? ST_BAD_VALUE : ST_OK;
                        ev_reg   <= '0;
                        hd_reg   <= '0;
                        hs_reg   <= '0;
                        pass_reg <= '0;
                        if (kind_t'(kind) == K_STORE && data_size[SIZE_BITS-1:0] == '0)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            cnt_reg   <= '0;
                            found_reg <= 1'b0;
                            mode_reg  <= SM_KEY;
                            ret_reg   <= S_DISPATCH;
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (elem_live && !found_reg && sr.hit)
                    begin
                        found_reg <= 1'b1;
                        s_reg     <= p_idx;
                        ent_reg   <= ram_rd_data;
                    end
                    if (cnt_reg == CNT_BITS'(SLOTS))
                    begin
                        state_reg <= ret_reg;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_DISPATCH:
                begin
                    if (kind_reg == K_STORE)
                    begin
                        state_reg <= S_STORE;
                    end
                    else if (kind_reg == K_RESERVE)
                    begin
                        if (found_reg)
                        begin
                            st_reg    <= ST_EXISTS;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            cnt_reg   <= '0;
                            found_reg <= 1'b0;
                            mode_reg  <= SM_FREE;
                            ret_reg   <= S_RES_ADD;
                            state_reg <= S_SCAN;
                        end
                    end
                    else if (!found_reg)
                    begin
                        st_reg    <= ST_NOT_FOUND;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        case (kind_reg)
                            K_QUERY:
                            begin
                                hd_reg    <= ent_reg.dsize;
                                hs_reg    <= ent_reg.ssize;
                                st_reg    <= (ent_reg.dsize == '0) ? ST_NOT_READY : ST_OK;
                                r_reg     <= ent_reg.rec;
                                cnt_reg   <= '0;
                                mode_reg  <= SM_DEC;
                                ret_reg   <= S_TOUCH;
                                state_reg <= S_SCAN;
                            end
                            K_EVICT:
                            begin
                                if (ent_reg.refs != '0)
                                begin
                                    st_reg    <= ST_REFUSED;
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    ret_reg   <= S_DONE;
                                    state_reg <= S_REM;
                                end
                            end
                            K_MARK_BAD:
                            begin
                                ent_reg.bad <= 1'b1;
                                ret_reg     <= S_DONE;
                                state_reg   <= S_WR;
                            end
                            K_ACQUIRE:
                            begin
                                if (ent_reg.refs != '1)
                                begin
                                    ent_reg.refs <= ent_reg.refs + 1'b1;
                                end
                                ret_reg   <= S_DONE;
                                state_reg <= S_WR;
                            end
                            K_RELEASE:
                            begin
                                if (ent_reg.refs != '0)
                                begin
                                    ent_reg.refs <= ent_reg.refs - 1'b1;
                                end
                                ret_reg   <= S_REL;
                                state_reg <= S_WR;
                            end
                            default:
                            begin
                                if (ent_reg.bad)
                                begin
                                    st_reg <= ST_BAD_VALUE;
                                end
                                else if (!ent_reg.filled)
                                begin
                                    st_reg <= ST_NOT_READY;
                                end
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_TOUCH:
                begin
                    ent_reg.rec <= IDX_BITS'(total_reg - 1'b1);
                    ret_reg     <= S_DONE;
                    state_reg   <= S_WR;
                end
                S_WR:
                begin
                    state_reg <= ret_reg;
                end
                S_REL:
                begin
                    if (!ent_reg.bad)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (ent_reg.refs != '0)
                    begin
                        st_reg    <= ST_REFUSED;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        ret_reg   <= S_DONE;
                        state_reg <= S_REM;
                    end
                end
                S_REM:
                begin
                    // drop the slot, then close the gap in the ranks above it
                    valid_reg[s_reg] <= 1'b0;
                    total_reg        <= total_reg - 1'b1;
                    bytes_reg        <= bytes_reg - BYTE_BITS'(ent_reg.ssize);
                    ev_reg           <= ev_reg + 1'b1;
                    r_reg            <= ent_reg.rec;
                    cnt_reg          <= '0;
                    mode_reg         <= SM_DEC;
                    state_reg        <= S_SCAN;
                end
                S_STORE:
                begin
                    if (!found_reg)
                    begin
                        fill_reg  <= 1'b0;
                        state_reg <= S_ROOM_N;
                    end
                    else if (ent_reg.filled)
                    begin
                        if (!cfg.evict_dup)
                        begin
                            st_reg    <= ST_EXISTS;
                            state_reg <= S_DONE;
                        end
                        else if (ent_reg.refs != '0)
                        begin
                            st_reg    <= ST_REFUSED;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            fill_reg  <= 1'b0;
                            ret_reg   <= S_ROOM_N;
                            state_reg <= S_REM;
                        end
                    end
                    else
                    begin
                        fill_reg   <= 1'b1;
                        before_reg <= ev_reg;
                        state_reg  <= S_ROOM_N;
                    end
                end
                S_ROOM_N:
                begin
                    if (NW'(cfg.max_entries) <= NW'(total_reg))
                    begin
                        if (!cfg.evict_on_full)
                        begin
                            st_reg    <= ST_FULL;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            ev_ret_reg <= S_ROOM_B;
                            cnt_reg    <= '0;
                            found_reg  <= 1'b0;
                            mode_reg   <= SM_OLDEST;
                            ret_reg    <= S_OLD;
                            state_reg  <= S_SCAN;
                        end
                    end
                    else
                    begin
                        state_reg <= S_ROOM_B;
                    end
                end
                S_OLD:
                begin
                    if (!found_reg)
                    begin
                        st_reg    <= ST_FULL;
                        state_reg <= S_DONE;
                    end
                    else if (ent_reg.refs != '0)
                    begin
                        st_reg    <= ST_REFUSED;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        freed_reg <= freed_reg + BYTE_BITS'(ent_reg.ssize);
                        ret_reg   <= ev_ret_reg;
                        state_reg <= S_REM;
                    end
                end
                S_ROOM_B:
                begin
                    avail_reg <= (cfg.max_bytes > bytes_reg) ? (cfg.max_bytes - bytes_reg) : '0;
                    state_reg <= S_ROOM_B2;
                end
                S_ROOM_B2:
                begin
                    if (BYTE_BITS'(ssz_reg) > avail_reg)
                    begin
                        if (!cfg.evict_on_full)
                        begin
                            st_reg    <= ST_FULL;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            need_reg  <= BYTE_BITS'(ssz_reg) - avail_reg;
                            freed_reg <= '0;
                            state_reg <= S_ROOM_LOOP;
                        end
                    end
                    else
                    begin
                        state_reg <= S_ROOM_OK;
                    end
                end
                S_ROOM_LOOP:
                begin
                    if (freed_reg < need_reg)
                    begin
                        ev_ret_reg <= S_ROOM_LOOP;
                        cnt_reg    <= '0;
                        found_reg  <= 1'b0;
                        mode_reg   <= SM_OLDEST;
                        ret_reg    <= S_OLD;
                        state_reg  <= S_SCAN;
                    end
                    else
                    begin
                        state_reg <= S_ROOM_OK;
                    end
                end
                S_ROOM_OK:
                begin
                    if (!fill_reg)
                    begin
                        cnt_reg   <= '0;
                        found_reg <= 1'b0;
                        mode_reg  <= SM_FREE;
                        ret_reg   <= S_ADD;
                        state_reg <= S_SCAN;
                    end
                    else if (ev_reg != before_reg)
                    begin
                        // the reserved slot may be gone: search the key again
                        pass_reg <= pass_reg + 1'b1;
                        if (pass_reg + 1'b1 == PASS_BITS'(PASS_LIMIT))
                        begin
                            fill_reg  <= 1'b0;
                            state_reg <= S_ROOM_N;
                        end
                        else
                        begin
                            cnt_reg   <= '0;
                            found_reg <= 1'b0;
                            mode_reg  <= SM_KEY;
                            ret_reg   <= S_STORE;
                            state_reg <= S_SCAN;
                        end
                    end
                    else
                    begin
                        ent_reg.filled <= 1'b1;
                        ent_reg.dsize  <= dsz_reg;
                        ent_reg.ssize  <= ssz_reg;
                        bytes_reg      <= bytes_reg + BYTE_BITS'(ssz_reg);
                        ret_reg        <= S_DONE;
                        state_reg      <= S_WR;
                    end
                end
                S_RES_ADD:
                begin
                    if (!found_reg)
                    begin
                        st_reg    <= ST_TABLE_FULL;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        ent_reg.key      <= key_reg;
                        ent_reg.filled   <= 1'b0;
                        ent_reg.dsize    <= '0;
                        ent_reg.ssize    <= '0;
                        ent_reg.refs     <= '0;
                        ent_reg.bad      <= 1'b0;
                        ent_reg.rec      <= IDX_BITS'(total_reg);
                        valid_reg[s_reg] <= 1'b1;
                        total_reg        <= total_reg + 1'b1;
                        ret_reg          <= S_DONE;
                        state_reg        <= S_WR;
                    end
                end
                S_ADD:
                begin
                    if (!found_reg)
                    begin
                        st_reg    <= ST_TABLE_FULL;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        ent_reg.key      <= key_reg;
                        ent_reg.filled   <= 1'b1;
                        ent_reg.dsize    <= dsz_reg;
                        ent_reg.ssize    <= ssz_reg;
                        ent_reg.refs     <= '0;
                        ent_reg.bad      <= 1'b0;
                        ent_reg.rec      <= IDX_BITS'(total_reg);
                        valid_reg[s_reg] <= 1'b1;
                        total_reg        <= total_reg + 1'b1;
                        bytes_reg        <= bytes_reg + BYTE_BITS'(ssz_reg);
                        ret_reg          <= S_DONE;
                        state_reg        <= S_WR;
                    end
                end
                S_DONE:
                begin
                    // hold until the result register is free
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= st_reg;
                        ohd_reg       <= hd_reg;
                        ohs_reg       <= hs_reg;
                        oev_reg       <= OCNT_BITS'(ev_reg);
                        oent_reg      <= OCNT_BITS'(total_reg);
                        obytes_reg    <= bytes_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/lru_keyed_cache_budget_manager.sv =====
// Keyed LRU cache budget manager: request and result channels (valid/ready),
// a plain write port for the four budget registers, and one transaction at a time.
// Requests (kind, key, sizes) are taken only while the sequencer is idle; each
// yields exactly one result (status, hit sizes, evictions, entry and byte use).
// The entry table sits in one RAM; every key search, least-recent search,
// free-slot search and rank update is a full sweep of that RAM through one
// shared compare unit.
// Besides its control states, each transaction runs these sweeps:
// acquire, mark_bad, check_ready and release of a good entry one sweep;
// query, evict, reserve and release of a bad entry two; a store with zero
// data size none, any other one to three plus two per entry evicted for it.
// At reset the slot valid bits and counts clear and the budgets take their
// reset values; no clearing pass is run, so requests are taken right away.
// A finished result waits in the output register; while it is stalled the next
// request is still accepted and worked on, and only its result waits.
// Depends on lkc_pkg, lkc_ram, lkc_scan and lkc_ctrl.
module lru_keyed_cache_budget_manager (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lkc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [lkc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [lkc_pkg::KIND_BITS-1:0]       kind,
    input  logic [63:0]                         key,
    input  logic [31:0]                         data_size,
    input  logic [31:0]                         store_size,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [lkc_pkg::STATUS_BITS-1:0]     status,
    output logic [31:0]                         hit_data_size,
    output logic [31:0]                         hit_store_size,
    output logic [lkc_pkg::OCNT_BITS-1:0]       evicted_count,
    output logic [lkc_pkg::OCNT_BITS-1:0]       used_entries,
    output logic [lkc_pkg::BYTE_BITS-1:0]       used_bytes
);
    import lkc_pkg::*;

    cfg_t                cfg_reg;
    logic                ram_we;
    logic [IDX_BITS-1:0] ram_wr_addr, ram_rd_addr;
    entry_t              ram_wr_data, ram_rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_bytes     <= '0;
            cfg_reg.max_entries   <= MAXE_BITS'(SLOTS);
            cfg_reg.evict_on_full <= 1'b0;
            cfg_reg.evict_dup     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_BYTES:   cfg_reg.max_bytes     <= cfg_data[BYTE_BITS-1:0];
                CFG_MAX_ENTRIES: cfg_reg.max_entries   <= cfg_data[MAXE_BITS-1:0];
                CFG_EVICT_FULL:  cfg_reg.evict_on_full <= cfg_data[0];
                CFG_EVICT_DUP:   cfg_reg.evict_dup     <= cfg_data[0];
                default:         cfg_reg               <= cfg_reg;
            endcase
        end
    end

    lkc_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    lkc_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .key            (key),
        .data_size      (data_size),
        .store_size     (store_size),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .hit_data_size  (hit_data_size),
        .hit_store_size (hit_store_size),
        .evicted_count  (evicted_count),
        .used_entries   (used_entries),
        .used_bytes     (used_bytes),
        .ram_we         (ram_we),
        .ram_wr_addr    (ram_wr_addr),
        .ram_wr_data    (ram_wr_data),
        .ram_rd_addr    (ram_rd_addr),
        .ram_rd_data    (ram_rd_data)
    );

endmodule

// ===== rtl/core/lkc_checker.sv =====
// Port-level checks for the keyed LRU cache budget manager, bound to its top level.
// Depends on lkc_pkg and lru_keyed_cache_budget_manager.
module lkc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [lkc_pkg::STATUS_BITS-1:0]   status,
    input logic [31:0]                       hit_data_size,
    input logic [31:0]                       hit_store_size,
    input logic [lkc_pkg::OCNT_BITS-1:0]     evicted_count,
    input logic [lkc_pkg::OCNT_BITS-1:0]     used_entries
);
    import lkc_pkg::*;

    // one transaction at a time: the request side closes after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while another is in flight");

    a_entries_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> used_entries <= OCNT_BITS'(SLOTS))
        else $error("entry count beyond table size");

    a_miss_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_NOT_FOUND || status == ST_EXISTS
                      || status == ST_BAD_VALUE) |-> evicted_count == '0)
        else $error("eviction reported on a request that changes nothing");

    a_hit_sizes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK && status != ST_NOT_READY
        |-> hit_data_size == '0 && hit_store_size == '0)
        else $error("hit sizes on a result without a hit");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("stalled result changed");

endmodule

bind lru_keyed_cache_budget_manager lkc_checker u_lkc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .hit_data_size  (hit_data_size),
    .hit_store_size (hit_store_size),
    .evicted_count  (evicted_count),
    .used_entries   (used_entries)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for lru_keyed_cache_budget_manager: directed table, then random phases.
// Results are checked against given outcomes or a cycle-free predictor. Depends on lkc_pkg.
module tb;
    import lkc_pkg::*;

    localparam int GAP_MAX       = 9;
    localparam int QUIET_LIMIT   = 40000;
    localparam int TAIL_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 100;
    localparam int POOL_SIZE     = 100;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 3'd5;
    localparam logic [39:0] BYTES_ALL = 40'hFF_FFFF_FFFF;

    typedef struct {
        status_t    st;
        bit [31:0]  hd;
        bit [31:0]  hs;
        bit [6:0]   ev;
        bit [6:0]   ue;
        bit [39:0]  ub;
    } outcome_t;

    typedef struct {
        kind_t      kd;
        bit [63:0]  k;
        bit [31:0]  ds;
        bit [31:0]  ss;
        bit         typed;
        outcome_t   want;
    } row_t;

    logic clk, rst_n;
    logic cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    logic in_valid, in_ready, out_valid, out_ready;
    logic [KIND_BITS-1:0] kind;
    logic [63:0] key;
    logic [31:0] data_size, store_size;
    logic [STATUS_BITS-1:0] status;
    logic [31:0] hit_data_size, hit_store_size;
    logic [OCNT_BITS-1:0] evicted_count, used_entries;
    logic [BYTE_BITS-1:0] used_bytes;

    lru_keyed_cache_budget_manager dut (.*);

    // mirror of the table and budget registers
    bit          m_valid [SLOTS];
    bit [63:0]   m_key   [SLOTS];
    bit          m_filled[SLOTS];
    bit [31:0]   m_dsz   [SLOTS];
    bit [31:0]   m_ssz   [SLOTS];
    int unsigned m_refs  [SLOTS];
    bit          m_bad   [SLOTS];
    int unsigned m_rank  [SLOTS];
    int unsigned n_entries;
    bit [39:0]   n_bytes;
    bit [39:0]   budget_bytes = 0;
    int unsigned budget_entries = 64;
    bit          evict_full = 0;
    bit          evict_dup = 0;

    outcome_t    owed_results[$];
    int          errors = 0;
    int          quiet = 0;
    bit          steady = 0;
    bit [63:0]   key_pool[POOL_SIZE];

    function automatic int find_key(bit [63:0] k);
        for (int i = 0; i < SLOTS; i++)
            if (m_valid[i] && m_key[i] == k)
                return i;
        return -1;
    endfunction

    function automatic int find_free();
        for (int i = 0; i < SLOTS; i++)
            if (!m_valid[i])
                return i;
        return -1;
    endfunction

    function automatic void touch(int s);
        int unsigned r;
        r = m_rank[s];
        for (int i = 0; i < SLOTS; i++)
            if (m_valid[i] && m_rank[i] > r)
                m_rank[i]--;
        m_rank[s] = n_entries - 1;
    endfunction

    function automatic bit drop_slot(int s, inout int ev);
        int unsigned r;
        if (m_refs[s] != 0)
            return 0;
        r = m_rank[s];
        m_valid[s] = 0;
        for (int i = 0; i < SLOTS; i++)
            if (m_valid[i] && m_rank[i] > r)
                m_rank[i]--;
        n_entries--;
        n_bytes = n_bytes - m_ssz[s];
        ev++;
        return 1;
    endfunction

    function automatic status_t drop_oldest(inout longint unsigned freed, inout int ev);
        int s;
        s = -1;
        for (int i = 0; i < SLOTS; i++)
            if (s < 0 && m_valid[i] && m_rank[i] == 0)
                s = i;
        if (s < 0)
            return ST_FULL;
        if (!drop_slot(s, ev))
            return ST_REFUSED;
        freed += m_ssz[s];
        return ST_OK;
    endfunction

    function automatic status_t make_room(bit [31:0] size, inout int ev);
        longint unsigned room, need, freed;
        status_t st;
        freed = 0;
        if (budget_entries <= n_entries) begin
            if (!evict_full)
                return ST_FULL;
            st = drop_oldest(freed, ev);
            if (st != ST_OK)
                return st;
        end
        room = (budget_bytes > n_bytes) ? budget_bytes - n_bytes : 0;
        if (size > room) begin
            if (!evict_full)
                return ST_FULL;
            need = size - room;
            freed = 0;
            while (freed < need) begin
                st = drop_oldest(freed, ev);
                if (st != ST_OK)
                    return st;
            end
        end
        return ST_OK;
    endfunction

    function automatic void add_entry(int s, bit [63:0] k, bit filled, bit [31:0] ds,
                                      bit [31:0] ss);
        m_valid[s] = 1;
        m_key[s] = k;
        m_filled[s] = filled;
        m_dsz[s] = ds;
        m_ssz[s] = ss;
        m_refs[s] = 0;
        m_bad[s] = 0;
        m_rank[s] = n_entries;
        n_entries++;
        n_bytes = n_bytes + ss;
    endfunction

    function automatic status_t store_entry(bit [63:0] k, bit [31:0] ds, bit [31:0] ss,
                                            inout int ev);
        int s, was;
        status_t st;
        if (ds == 0)
            return ST_BAD_VALUE;
        for (int pass = 0; pass < PASS_LIMIT; pass++) begin
            s = find_key(k);
            if (s < 0)
                break;
            if (m_filled[s]) begin
                if (!evict_dup)
                    return ST_EXISTS;
                if (!drop_slot(s, ev))
                    return ST_REFUSED;
                break;
            end
            was = ev;
            st = make_room(ss, ev);
            if (st != ST_OK)
                return st;
            // a reserved entry may have gone in the walk: search again
            if (ev != was)
                continue;
            m_filled[s] = 1;
            m_dsz[s] = ds;
            m_ssz[s] = ss;
            n_bytes = n_bytes + ss;
            return ST_OK;
        end
        st = make_room(ss, ev);
        if (st != ST_OK)
            return st;
        s = find_free();
        if (s < 0)
            return ST_TABLE_FULL;
        add_entry(s, k, 1, ds, ss);
        return ST_OK;
    endfunction

    function automatic outcome_t serve_request(kind_t kd, bit [63:0] k, bit [31:0] ds,
                                               bit [31:0] ss);
        outcome_t o;
        int s, ev;
        ev = 0;
        o.st = ST_OK;
        o.hd = 0;
        o.hs = 0;
        if (kd == K_STORE) begin
            o.st = store_entry(k, ds, ss, ev);
        end else if (kd == K_RESERVE) begin
            if (find_key(k) >= 0)
                o.st = ST_EXISTS;
            else begin
                s = find_free();
                if (s < 0)
                    o.st = ST_TABLE_FULL;
                else
                    add_entry(s, k, 0, 0, 0);
            end
        end else begin
            s = find_key(k);
            if (s < 0)
                o.st = ST_NOT_FOUND;
            else
                case (kd)
                    K_QUERY: begin
                        touch(s);
                        o.hd = m_dsz[s];
                        o.hs = m_ssz[s];
                        if (o.hd == 0)
                            o.st = ST_NOT_READY;
                    end
                    K_EVICT:
                        if (!drop_slot(s, ev))
                            o.st = ST_REFUSED;
                    K_MARK_BAD:
                        m_bad[s] = 1;
                    K_ACQUIRE:
                        if (m_refs[s] < 16'hFFFF)
                            m_refs[s]++;
                    K_RELEASE: begin
                        if (m_refs[s] > 0)
                            m_refs[s]--;
                        if (m_bad[s] && !drop_slot(s, ev))
                            o.st = ST_REFUSED;
                    end
                    default:
                        if (m_bad[s])
                            o.st = ST_BAD_VALUE;
                        else if (!m_filled[s])
                            o.st = ST_NOT_READY;
                endcase
        end
        o.ev = 7'(ev);
        o.ue = 7'(n_entries);
        o.ub = n_bytes;
        return o;
    endfunction

    task automatic report(string field, longint unsigned got, longint unsigned want);
        $display("mismatch at %0t: %s got %0h expected %0h", $time, field, got, want);
        errors++;
    endtask

    task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            CFG_MAX_BYTES:   budget_bytes = val;
            CFG_MAX_ENTRIES: budget_entries = val[6:0];
            CFG_EVICT_FULL:  evict_full = val[0];
            CFG_EVICT_DUP:   evict_dup = val[0];
            default: ;
        endcase
    endtask

    // drain, then rewrite every register (plus one write to an unused index)
    task automatic configure(bit [39:0] mb, bit [6:0] me, bit ef, bit ed);
        in_valid <= 1'b0;
        wait (owed_results.size() == 0);
        repeat (5) @(posedge clk);
        cfg_write(CFG_SPARE, '1);
        cfg_write(CFG_MAX_BYTES, mb);
        cfg_write(CFG_MAX_ENTRIES, me);
        cfg_write(CFG_EVICT_FULL, ef);
        cfg_write(CFG_EVICT_DUP, ed);
        cfg_we <= 1'b0;
    endtask

    task automatic send(kind_t kd, bit [63:0] k, bit [31:0] ds, bit [31:0] ss, bit typed,
                        outcome_t want);
        int gap;
        outcome_t o;
        gap = steady ? 0 : $urandom_range(GAP_MAX);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= kd;
        key <= k;
        data_size <= ds;
        store_size <= ss;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        o = serve_request(kd, k, ds, ss);
        owed_results.push_back(typed ? want : o);
    endtask

    function automatic outcome_t res(status_t st, int ev, int ue, bit [39:0] ub);
        outcome_t o;
        o.st = st;
        o.hd = 0;
        o.hs = 0;
        o.ev = 7'(ev);
        o.ue = 7'(ue);
        o.ub = ub;
        return o;
    endfunction

    task automatic random_phase(int pool);
        kind_t kd;
        bit [63:0] k;
        bit [31:0] ds, ss;
        int pick;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2) begin
                in_valid <= 1'b0;
                wait (owed_results.size() == 0);
            end
            pick = $urandom_range(99);
            if (pick < 35)      kd = K_STORE;
            else if (pick < 55) kd = K_QUERY;
            else if (pick < 65) kd = K_RESERVE;
            else if (pick < 72) kd = K_EVICT;
            else if (pick < 77) kd = K_MARK_BAD;
            else if (pick < 85) kd = K_ACQUIRE;
            else if (pick < 93) kd = K_RELEASE;
            else                kd = K_CHECK_READY;
            k = ($urandom_range(19) == 0) ? {$urandom, $urandom}
                                          : key_pool[$urandom_range(pool - 1)];
            pick = $urandom_range(19);
            ds = (pick == 0) ? 32'd0 : (pick == 1) ? $urandom : $urandom_range(1, 500);
            ss = ($urandom_range(29) == 0) ? $urandom : $urandom_range(0, 200);
            send(kd, k, ds, ss, 1'b0, res(ST_OK, 0, 0, 0));
        end
    endtask

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: stall a random number of cycles per result (none when steady), then check it
    initial begin
        int stall;
        outcome_t w;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            stall = steady ? 0 : $urandom_range(GAP_MAX);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            if (owed_results.size() == 0) begin
                report("unexpected result", 1, 0);
            end else begin
                w = owed_results.pop_front();
                if (status !== w.st)            report("status", status, w.st);
                if (hit_data_size !== w.hd)     report("hit_data_size", hit_data_size, w.hd);
                if (hit_store_size !== w.hs)    report("hit_store_size", hit_store_size, w.hs);
                if (evicted_count !== w.ev)     report("evicted_count", evicted_count, w.ev);
                if (used_entries !== w.ue)      report("used_entries", used_entries, w.ue);
                if (used_bytes !== w.ub)        report("used_bytes", used_bytes, w.ub);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        row_t plan[$];
        outcome_t nil;
        bit [63:0] k1, kmax;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        kind = '0;
        key = '0;
        data_size = '0;
        store_size = '0;
        n_entries = 0;
        n_bytes = 0;
        foreach (m_valid[i])
            m_valid[i] = 0;
        foreach (key_pool[i])
            key_pool[i] = {$urandom, $urandom};
        k1 = 64'h1;
        kmax = '1;
        nil = res(ST_OK, 0, 0, 0);
        // reset budgets: no bytes, 64 entries, refuse when full
        plan = '{
            '{K_QUERY,       k1,   32'd0,  32'd0,  1, res(ST_NOT_FOUND, 0, 0, 0)},
            '{K_STORE,       k1,   32'd0,  32'd7,  1, res(ST_BAD_VALUE, 0, 0, 0)},
            '{K_STORE,       k1,   32'd5,  32'd1,  1, res(ST_FULL, 0, 0, 0)},
            '{K_STORE,       k1,   '1,     '1,     1, res(ST_FULL, 0, 0, 0)},
            '{K_STORE,       k1,   32'd5,  32'd0,  1, res(ST_OK, 0, 1, 0)},
            '{K_STORE,       k1,   32'd9,  32'd0,  1, res(ST_EXISTS, 0, 1, 0)},
            '{K_RESERVE,     kmax, 32'd0,  32'd0,  1, res(ST_OK, 0, 2, 0)},
            '{K_RESERVE,     kmax, 32'd0,  32'd0,  1, res(ST_EXISTS, 0, 2, 0)},
            '{K_QUERY,       kmax, 32'd0,  32'd0,  1, res(ST_NOT_READY, 0, 2, 0)},
            '{K_CHECK_READY, kmax, 32'd0,  32'd0,  1, res(ST_NOT_READY, 0, 2, 0)},
            '{K_CHECK_READY, 64'd0, 32'd0, 32'd0,  1, res(ST_NOT_FOUND, 0, 2, 0)},
            '{K_CHECK_READY, k1,   32'd0,  32'd0,  1, res(ST_OK, 0, 2, 0)},
            '{K_QUERY,       k1,   32'd0,  32'd0,  0, nil},
            '{K_ACQUIRE,     k1,   32'd0,  32'd0,  1, res(ST_OK, 0, 2, 0)},
            '{K_ACQUIRE,     k1,   32'd0,  32'd0,  1, res(ST_OK, 0, 2, 0)},
            '{K_EVICT,       k1,   32'd0,  32'd0,  1, res(ST_REFUSED, 0, 2, 0)},
            '{K_MARK_BAD,    k1,   32'd0,  32'd0,  1, res(ST_OK, 0, 2, 0)},
            '{K_CHECK_READY, k1,   32'd0,  32'd0,  1, res(ST_BAD_VALUE, 0, 2, 0)},
            '{K_RELEASE,     k1,   32'd0,  32'd0,  1, res(ST_REFUSED, 0, 2, 0)},
            '{K_RELEASE,     k1,   32'd0,  32'd0,  1, res(ST_OK, 1, 1, 0)},
            '{K_RELEASE,     kmax, 32'd0,  32'd0,  0, nil},
            '{K_STORE,       kmax, 32'd3,  32'd0,  0, nil},
            '{K_EVICT,       kmax, 32'd0,  32'd0,  0, nil},
            '{K_MARK_BAD,    64'd2, 32'd0, 32'd0,  1, res(ST_NOT_FOUND, 0, 0, 0)}
        };
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (plan[i])
            send(plan[i].kd, plan[i].k, plan[i].ds, plan[i].ss, plan[i].typed, plan[i].want);

        configure(40'd1000, 7'd8, 1'b1, 1'b1);
        random_phase(12);
        configure(BYTES_ALL, 7'd64, 1'b0, 1'b0);
        random_phase(POOL_SIZE);
        configure(40'd0, 7'd0, 1'b1, 1'b0);
        random_phase(10);
        steady = 1;
        configure(40'd300, 7'd64, 1'b1, 1'b1);
        random_phase(20);
        steady = 0;
        configure(40'd5000, 7'd16, 1'b0, 1'b1);
        random_phase(24);

        in_valid <= 1'b0;
        wait (owed_results.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/lkc_pkg.sv
rtl/core/lkc_ram.sv
rtl/core/lkc_scan.sv
rtl/core/lkc_ctrl.sv
rtl/core/lru_keyed_cache_budget_manager.sv
rtl/core/lkc_checker.sv
tb/sv/tb.sv
